@@ hw/rtl/lpwd_pkg.sv @@
// Shared types and constants for the length-prefixed WAV deframer.
package lpwd_pkg;

    // Input mode codes (s_tuser)
    localparam logic [1:0] MODE_DATA    = 2'd0;
    localparam logic [1:0] MODE_CANCEL  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Result kind codes (m_tuser)
    localparam logic [1:0] KIND_SAMPLE    = 2'd0;
    localparam logic [1:0] KIND_FRAME_END = 2'd1;
    localparam logic [1:0] KIND_BAD_LEN   = 2'd2;
    localparam logic [1:0] KIND_CANCEL    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAX_FRAME_LEN = 1'b0;
    localparam logic CFG_HEADER_SKIP   = 1'b1;

    localparam logic [31:0] MAX_FRAME_LEN_RST = 32'd2097152;
    localparam logic [7:0]  HEADER_SKIP_RST   = 8'd44;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_CANCEL,
        OP_RESTART
    } op_t;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_PAYLOAD,
        PH_STOPPED
    } phase_t;

    // One classified command handed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    // Queue output toward the back end: valid flag and head command
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

endpackage

@@ hw/rtl/lpwd_front.sv @@
// Front end: classifies incoming transfers and queues them for the back end.
module lpwd_front
    import lpwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  logic [7:0] s_tdata,
    output cmd_chan_t  cmd_out,
    input  logic       cmd_pop
);

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    op_t        op;
    logic       push;
    logic       pop;

    // Unused mode code is accepted and dropped here
    always_comb
    begin
        keep = 1'b1;
        op   = OP_DATA;
        unique case (s_tuser)
            MODE_DATA:    op = OP_DATA;
            MODE_CANCEL:  op = OP_CANCEL;
            MODE_RESTART: op = OP_RESTART;
            default:      keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = cmd_pop && (count_reg != 2'd0);

    assign cmd_out.valid = (count_reg != 2'd0);
    assign cmd_out.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{op: op, data: s_tdata};
        end
    end

endmodule

@@ hw/rtl/lpwd_back.sv @@
// Back end: frame parser, sample pairing, frame counter and output register.
module lpwd_back
    import lpwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  cmd_chan_t   cmd_in,
    output logic        cmd_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  kind,
    output logic [15:0] sample,
    output logic        frame_end,
    output logic [15:0] frames_done
);

    logic [31:0] max_len_reg;
    logic [7:0]  skip_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] pos_reg, pos_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] cnt_reg, cnt_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] sample_reg, sample_next;
    logic        fend_reg, fend_next;
    logic [15:0] done_reg, done_next;

    logic        emit;
    logic        active;
    logic [31:0] acc_shift;
    logic [31:0] pos_inc;
    logic        in_samples;
    logic        odd;
    logic        last;

    assign cmd_pop    = cmd_in.valid && (!out_valid_reg || m_tready);
    assign active     = (phase_reg == PH_LENGTH) || (phase_reg == PH_PAYLOAD);
    assign acc_shift  = {acc_reg[23:0], cmd_in.cmd.data};
    assign pos_inc    = pos_reg + 32'd1;
    assign in_samples = (pos_reg >= {24'd0, skip_reg});
    assign odd        = pos_reg[0] ^ skip_reg[0];
    assign last       = (pos_inc == acc_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        cnt_next    = cnt_reg;
        emit        = 1'b0;
        kind_next   = KIND_SAMPLE;
        sample_next = 16'd0;
        fend_next   = 1'b0;
        done_next   = cnt_reg;
        if (cmd_pop)
        begin
            unique case (cmd_in.cmd.op)
                OP_RESTART:
                begin
                    phase_next = PH_LENGTH;
                    idx_next   = 2'd0;
                    acc_next   = 32'd0;
                    pos_next   = 32'd0;
                    hold_next  = 8'd0;
                    cnt_next   = 16'd0;
                end
                OP_CANCEL:
                begin
                    if (active)
                    begin
                        phase_next = PH_STOPPED;
                        emit       = 1'b1;
                        kind_next  = KIND_CANCEL;
                    end
                end
                OP_DATA:
                begin
                    if (phase_reg == PH_LENGTH)
                    begin
                        acc_next = acc_shift;
                        idx_next = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            if ((acc_shift == 32'd0) || (acc_shift > max_len_reg))
                            begin
                                phase_next = PH_STOPPED;
                                emit       = 1'b1;
                                kind_next  = KIND_BAD_LEN;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                                pos_next   = 32'd0;
                            end
                        end
                    end
                    else if (phase_reg == PH_PAYLOAD)
                    begin
                        pos_next = pos_inc;
                        if (in_samples && !odd)
                        begin
                            hold_next = cmd_in.cmd.data;
                        end
                        if (in_samples && odd)
                        begin
                            emit        = 1'b1;
                            kind_next   = KIND_SAMPLE;
                            sample_next = {cmd_in.cmd.data, hold_reg};
                        end
                        if (last)
                        begin
                            cnt_next   = cnt_reg + 16'd1;
                            done_next  = cnt_reg + 16'd1;
                            phase_next = PH_LENGTH;
                            idx_next   = 2'd0;
                            acc_next   = 32'd0;
                            pos_next   = 32'd0;
                            fend_next  = 1'b1;
                            emit       = 1'b1;
                            if (!(in_samples && odd))
                            begin
                                kind_next = KIND_FRAME_END;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_FRAME_LEN_RST;
            skip_reg      <= HEADER_SKIP_RST;
            phase_reg     <= PH_LENGTH;
            idx_reg       <= 2'd0;
            acc_reg       <= 32'd0;
            pos_reg       <= 32'd0;
            hold_reg      <= 8'd0;
            cnt_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_MAX_FRAME_LEN))
            begin
                max_len_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_HEADER_SKIP))
            begin
                skip_reg <= cfg_data[7:0];
            end
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            hold_reg  <= hold_next;
            cnt_reg   <= cnt_next;
            if (cmd_pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && emit)
        begin
            kind_reg   <= kind_next;
            sample_reg <= sample_next;
            fend_reg   <= fend_next;
            done_reg   <= done_next;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign kind        = kind_reg;
    assign sample      = sample_reg;
    assign frame_end   = fend_reg;
    assign frames_done = done_reg;

endmodule

@@ hw/rtl/length_prefixed_wav_deframer.sv @@
// Top level of the length-prefixed WAV deframer.
//
// Takes a response byte stream of frames, each a 4-byte big-endian length
// followed by a WAV payload. The first header_skip payload bytes are dropped,
// the rest are paired low byte first into signed 16-bit mono samples, which
// go out duplicated on left and right. A length of zero or above
// max_frame_len gives a bad-length result and stops the block; cancel also
// stops it (one cancelled result), and restart clears all stream state and
// the frame counter. The last payload byte of a frame closes it with tlast
// set, either on its sample or on a frame-end result. One transfer is taken
// every clock while the queue has room: the front end classifies each
// transfer into a two-entry queue, and the back end drains one queued
// command per cycle into a single output register while it is empty or
// m_tready is high; with m_tready high the block keeps that rate. A result
// is held in the queue and then the output register before m_tvalid rises.
// The unused mode code is accepted and dropped. Configuration is taken on
// any cycle with cfg_we high and must only change while the block is idle.
module length_prefixed_wav_deframer
    import lpwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] left, [31:16] right, [47:32] frames_done
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // frame_end
);

    cmd_chan_t   cmd;
    logic        cmd_pop;
    logic [15:0] sample;
    logic [15:0] frames_done;

    lpwd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd_out  (cmd),
        .cmd_pop  (cmd_pop)
    );

    lpwd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_in      (cmd),
        .cmd_pop     (cmd_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .kind        (m_tuser),
        .sample      (sample),
        .frame_end   (m_tlast),
        .frames_done (frames_done)
    );

    // mono sample copied to both channels
    assign m_tdata = {frames_done, sample, sample};

endmodule

@@ hw/rtl/lpwd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module lpwd_checker
    import lpwd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_stereo: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] == m_tdata[31:16])
        else $error("left and right differ");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_SAMPLE |-> m_tdata[31:0] == 32'd0)
        else $error("non-sample result carries sample data");

    a_stop_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_BAD_LEN || m_tuser == KIND_CANCEL) |-> !m_tlast)
        else $error("stop result marked as frame end");

    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FRAME_END |-> m_tlast)
        else $error("frame-end result without tlast");

endmodule

bind length_prefixed_wav_deframer lpwd_checker u_lpwd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ verif/length_prefixed_wav_deframer_test.sv @@
// Self-checking testbench for the length-prefixed WAV deframer.
`timescale 1ns / 100ps

module length_prefixed_wav_deframer_test
    import lpwd_pkg::*;
;

    localparam int TAIL_CYCLES = 8;     // margin after the drain for results still in flight
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One input transfer: mode in tuser, byte in tdata
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
    } rx_item_t;

    // One result transfer, split into its fields
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] left;
        logic [15:0] right;
        logic        frame_end;
        logic [15:0] frames_done;
    } wav_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic [1:0]  s_tuser = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [15:0] left, [31:16] right, [47:32] frames_done
    logic [1:0]  m_tuser;        // [1:0] kind
    logic        m_tlast;        // frame_end

    length_prefixed_wav_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Stimulus and expectation stores
    rx_item_t    response_bytes[$];
    wav_result_t deframed_results[$];

    // Idle percentages for both sides, changed only while the stream is drained
    int send_idle_pct = 14;
    int recv_idle_pct = 56;

    // Counters
    int live_items = 0;       // queued items that the block acts on
    int items_accepted = 0;
    int results_seen = 0;
    int samples_seen = 0;
    int frame_closes = 0;
    int stops_seen = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    // Predictor copy of the configuration registers
    logic [31:0] max_len_cfg = MAX_FRAME_LEN_RST;
    logic [7:0]  skip_cfg = HEADER_SKIP_RST;

    // Predictor copy of the stream state
    phase_t      rx_phase = PH_LENGTH;
    logic [1:0]  len_idx = '0;
    logic [31:0] frame_len = '0;
    logic [31:0] payload_pos = '0;
    logic [7:0]  low_hold = '0;
    logic [15:0] frame_count = '0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: advances the state copy by one input transfer and
    // returns 1 with the result when the transfer produces one.
    // ------------------------------------------------------------------
    function automatic bit deframe_step(input logic [1:0] mode, input logic [7:0] rx,
                                        output wav_result_t res);
        logic        active;
        logic        last;
        logic        have_sample;
        logic [31:0] pos;
        logic [31:0] off;
        logic [15:0] sample;
        active = (rx_phase == PH_LENGTH) || (rx_phase == PH_PAYLOAD);
        res = '0;
        have_sample = 1'b0;
        sample = '0;

        // Restart wipes everything but the registers, no result
        if (mode == MODE_RESTART)
        begin
            rx_phase = PH_LENGTH;
            len_idx = '0;
            frame_len = '0;
            payload_pos = '0;
            low_hold = '0;
            frame_count = '0;
            return 1'b0;
        end

        // Cancel reports once, then the block sits stopped
        if (mode == MODE_CANCEL)
        begin
            if (!active)
                return 1'b0;
            rx_phase = PH_STOPPED;
            res.kind = KIND_CANCEL;
            res.frames_done = frame_count;
            return 1'b1;
        end

        // Unused mode code and bytes while stopped are dropped
        if (mode != MODE_DATA || !active)
            return 1'b0;

        // Length prefix, most significant byte first
        if (rx_phase == PH_LENGTH)
        begin
            frame_len = {frame_len[23:0], rx};
            len_idx = len_idx + 2'd1;
            if (len_idx != 2'd0)
                return 1'b0;
            if (frame_len == 32'd0 || frame_len > max_len_cfg)
            begin
                rx_phase = PH_STOPPED;
                res.kind = KIND_BAD_LEN;
                res.frames_done = frame_count;
                return 1'b1;
            end
            rx_phase = PH_PAYLOAD;
            payload_pos = '0;
            return 1'b0;
        end

        // Payload: skip the header, then pair bytes low first
        pos = payload_pos;
        last = (pos + 32'd1 == frame_len);
        if (pos >= {24'd0, skip_cfg})
        begin
            off = pos - {24'd0, skip_cfg};
            if (!off[0])
                low_hold = rx;
            else
            begin
                sample = {rx, low_hold};
                have_sample = 1'b1;
            end
        end
        payload_pos = pos + 32'd1;

        if (last)
        begin
            frame_count = frame_count + 16'd1;
            rx_phase = PH_LENGTH;
            len_idx = '0;
            frame_len = '0;
            payload_pos = '0;
            res.kind = have_sample ? KIND_SAMPLE : KIND_FRAME_END;
            res.left = sample;
            res.right = sample;
            res.frame_end = 1'b1;
            res.frames_done = frame_count;
            return 1'b1;
        end
        if (have_sample)
        begin
            res.kind = KIND_SAMPLE;
            res.left = sample;
            res.right = sample;
            res.frames_done = frame_count;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR result %0d: %s", $realtime, results_seen, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: holds tvalid until the transfer is taken, then pulls the
    // next item. The item seen at an accepting edge goes to the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_item_t    item;
        wav_result_t res;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                items_accepted++;
                if (deframe_step(s_tuser, s_tdata, res))
                    deframed_results.push_back(res);
            end
            if (!s_tvalid || s_tready)
            begin
                if (response_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item = response_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.data;
                    s_tuser <= item.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, and each result transfer is checked
    // field by field against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        wav_result_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (deframed_results.size() == 0)
                    report_mismatch($sformatf("unexpected result, kind %0d", m_tuser));
                else
                begin
                    want = deframed_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_tuser, want.kind));
                    if (m_tdata[15:0] !== want.left)
                        report_mismatch($sformatf("left %h, expected %h",
                                                  m_tdata[15:0], want.left));
                    if (m_tdata[31:16] !== want.right)
                        report_mismatch($sformatf("right %h, expected %h",
                                                  m_tdata[31:16], want.right));
                    if (m_tlast !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  m_tlast, want.frame_end));
                    if (m_tdata[47:32] !== want.frames_done)
                        report_mismatch($sformatf("frames_done %0d, expected %0d",
                                                  m_tdata[47:32], want.frames_done));
                    if (want.kind == KIND_SAMPLE)
                        samples_seen++;
                    if (want.frame_end)
                        frame_closes++;
                    if (want.kind == KIND_BAD_LEN || want.kind == KIND_CANCEL)
                        stops_seen++;
                end
            end
        end
    end

    // Watchdog: any transfer on either side resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, deframed_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] mode, input logic [7:0] data, input bit live);
        rx_item_t item;
        item.mode = mode;
        item.data = data;
        response_bytes.push_back(item);
        if (live)
            live_items++;
    endtask

    // First nbytes of the big-endian length prefix
    task automatic push_length(input logic [31:0] len, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            push_item(MODE_DATA, len[31 - 8 * i -: 8], 1'b1);
    endtask

    task automatic push_payload(input int count);
        for (int i = 0; i < count; i++)
            push_item(MODE_DATA, 8'($urandom), 1'b1);
    endtask

    task automatic push_frame(input logic [31:0] len);
        push_length(len, 4);
        push_payload(len);
    endtask

    // Mostly just past the header so samples come out; kept within max_len_cfg
    function automatic logic [31:0] pick_frame_len();
        logic [31:0] len;
        if ($urandom_range(0, 99) < 80)
            len = skip_cfg + $urandom_range(0, 24);
        else
            len = $urandom_range(1, skip_cfg + 2);
        if (len == 32'd0)
            len = 32'd1;
        if (len > max_len_cfg)
            len = $urandom_range(1, max_len_cfg);
        return len;
    endfunction

    // Random traffic: mostly whole frames, the rest cancels, bad lengths,
    // restarts in mid frame and unused-mode noise. Every sequence leaves
    // the block back in the length phase.
    task automatic gen_traffic(input int budget);
        int          stop_at;
        int          pick;
        logic [31:0] len;
        stop_at = live_items + budget;
        while (live_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                push_frame(pick_frame_len());
            else if (pick < 76)
            begin
                // cancel part way through a frame
                len = pick_frame_len();
                push_length(len, 4);
                push_payload($urandom_range(0, len - 1));
                push_item(MODE_CANCEL, 8'($urandom), 1'b1);
                if ($urandom_range(0, 1))
                    push_item(MODE_CANCEL, 8'($urandom), 1'b0);
                push_item(MODE_DATA, 8'($urandom), 1'b0);
                push_item(MODE_RESTART, 8'($urandom), 1'b1);
            end
            else if (pick < 83)
            begin
                // zero length, one over the limit or a random length above it
                if (max_len_cfg == '1 || $urandom_range(0, 2) == 0)
                    len = '0;
                else if ($urandom_range(0, 1))
                    len = max_len_cfg + 32'd1;
                else
                begin
                    len = $urandom;
                    if (len <= max_len_cfg)
                        len = max_len_cfg + 32'd1;
                end
                push_length(len, 4);
                repeat ($urandom_range(0, 3))
                    push_item(MODE_DATA, 8'($urandom), 1'b0);
                push_item(MODE_RESTART, 8'($urandom), 1'b1);
            end
            else if (pick < 89)
            begin
                // restart inside the prefix or inside the payload
                len = pick_frame_len();
                if ($urandom_range(0, 1))
                    push_length(len, $urandom_range(1, 3));
                else
                begin
                    push_length(len, 4);
                    push_payload($urandom_range(0, len - 1));
                end
                push_item(MODE_RESTART, 8'($urandom), 1'b1);
            end
            else if (pick < 94)
            begin
                repeat ($urandom_range(1, 3))
                    push_item(MODE_UNUSED, 8'($urandom), 1'b0);
                if ($urandom_range(0, 1))
                begin
                    push_item(MODE_CANCEL, 8'($urandom), 1'b1);
                    push_item(MODE_RESTART, 8'($urandom), 1'b1);
                end
            end
            else
            begin
                // boundary lengths: header only, one past it, the limit (or two past the header), one byte
                case ($urandom_range(0, 3))
                    0: len = skip_cfg;
                    1: len = skip_cfg + 32'd1;
                    2: len = (max_len_cfg <= skip_cfg + 40) ? max_len_cfg : skip_cfg + 32'd2;
                    default: len = 32'd1;
                endcase
                if (len > max_len_cfg)
                    len = max_len_cfg;
                if (len == 32'd0)
                    len = 32'd1;
                push_frame(len);
            end
        end
    endtask

    // Checked at the falling edge, when the driver and monitor have settled.
    // Expectations cover every transfer still inside the block.
    task automatic wait_idle(input int tail);
        while (response_bytes.size() != 0 || s_tvalid || deframed_results.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_MAX_FRAME_LEN)
            max_len_cfg = value;
        else
            skip_cfg = value[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One configuration setting: drain, reprogram, then random traffic with
    // a full drain half way so the sender sits out until all results are in.
    task automatic run_phase(input logic [31:0] max_len, input logic [7:0] skip,
                             input int send_pct, input int recv_pct, input int budget);
        wait_idle(TAIL_CYCLES);
        write_reg(CFG_MAX_FRAME_LEN, max_len);
        write_reg(CFG_HEADER_SKIP, {24'd0, skip});
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        gen_traffic(budget / 2);
        wait_idle(0);
        gen_traffic(budget - budget / 2);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: two-byte header, frames of at most five bytes
        write_reg(CFG_MAX_FRAME_LEN, 32'd5);
        write_reg(CFG_HEADER_SKIP, 32'd2);
        @(negedge clk);

        // Frame at the limit: most negative sample, then an odd trailing byte
        push_length(32'd5, 4);
        push_item(MODE_DATA, 8'hAA, 1'b1);
        push_item(MODE_DATA, 8'hBB, 1'b1);
        push_item(MODE_DATA, 8'h00, 1'b1);
        push_item(MODE_DATA, 8'h80, 1'b1);
        push_item(MODE_DATA, 8'h33, 1'b1);
        // Frame shorter than the header
        push_length(32'd1, 4);
        push_item(MODE_DATA, 8'h5A, 1'b1);
        // Unused mode code
        push_item(MODE_UNUSED, 8'hFF, 1'b0);
        // Most positive sample, then cancel with the frame still open
        push_length(32'd5, 4);
        push_item(MODE_DATA, 8'h11, 1'b1);
        push_item(MODE_DATA, 8'h22, 1'b1);
        push_item(MODE_DATA, 8'hFF, 1'b1);
        push_item(MODE_DATA, 8'h7F, 1'b1);
        push_item(MODE_CANCEL, 8'h00, 1'b1);
        // Stopped: cancel and data are dropped, restart recovers
        push_item(MODE_CANCEL, 8'h00, 1'b1);
        push_item(MODE_DATA, 8'hFF, 1'b1);
        push_item(MODE_RESTART, 8'h00, 1'b1);

        // Random part over several settings and the three idle patterns.
        // At the largest header one frame is already a few hundred bytes,
        // so that setting gets a single sequence.
        run_phase(MAX_FRAME_LEN_RST, HEADER_SKIP_RST, 14, 56, 80);
        run_phase(32'd1, 8'd0, 14, 56, 70);
        run_phase(32'hFFFF_FFFF, 8'd255, 56, 14, 1);
        run_phase(32'd40, 8'd3, 56, 14, 70);
        run_phase(32'hFFFF_FFFF, 8'd0, 0, 0, 70);
        run_phase($urandom_range(10, 60), 8'($urandom_range(0, 20)), 0, 0, 60);

        wait_idle(TAIL_CYCLES);

        $display("Covered %0d input transfers, %0d results: %0d samples, %0d frame ends, %0d stops",
                 items_accepted, results_seen, samples_seen, frame_closes, stops_seen);
        $display("Limits from 1 to all ones, header skips 0 to 255, with and without idling");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
